FILE: hw/rtl/tbpa_pkg.sv
// Shared constants, register codes and helpers of the temporal band-pass amplifier.
`timescale 1ns / 1ps

package tbpa_pkg;

    // Default sizes
    localparam int LEVELS_DEF       = 4;
    localparam int STORE_DEPTH_DEF  = 131072;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int NUM_CHAN  = 3;
    localparam int ADDR_W    = 17;
    localparam int LEVEL_W   = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_W    = 16;
    localparam int KW        = COEF_W + 1;

    // Channel positions
    localparam int CH_L = 0;
    localparam int CH_A = 1;
    localparam int CH_B = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_HIGH   = 3'd0,
        CFG_COEF_LOW    = 3'd1,
        CFG_CHROMA_GAIN = 3'd2,
        CFG_GAIN_LEVEL1 = 3'd3,
        CFG_GAIN_LEVEL2 = 3'd4,
        CFG_GAIN_LEVEL3 = 3'd5
    } cfg_index_t;

    // Pyramid level codes
    localparam logic [LEVEL_W-1:0] LEVEL_FINEST = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE    = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO    = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE  = 3'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] COEF_HIGH_RST   = 16'd26214;
    localparam logic [CFG_W-1:0] COEF_LOW_RST    = 16'd3277;
    localparam logic [CFG_W-1:0] CHROMA_GAIN_RST = 16'd6554;
    localparam logic [CFG_W-1:0] GAIN_LEVEL_RST  = 16'd2560;

    // One in Q1.16, used for the complement of a low-pass coefficient
    localparam logic [KW-1:0] ONE_Q16 = 17'h10000;

    // Count the conditional subtract steps that fold an address into the store
    function automatic int mod_steps(input int depth);
        int n;
        n = 0;
        while ((longint'(depth) << n) <= longint'((1 << ADDR_W) - 1)) begin
            n = n + 1;
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/temporal_bandpass_amplifier_top.sv
// Temporal band-pass amplifier: per-address dual low-pass filter, level gain and chroma scaling.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// s_        s_valid / s_ready      s_level, s_address, s_first_frame, s_chan_l/a/b
// m_        m_valid / m_ready      m_out_address, m_motion_l/a/b
// cfg_      cfg_we (no wait)       cfg_index, cfg_wdata
//
// One beat enters per cycle while s_ready is high; stages A-F and the m_ register follow.
// The rate is set by the per-address low-pass recurrence, one multiply-add in stage C,
// with results of the two younger writes forwarded around the state memory.
// Reset clears valid bits, the output/skid stage and the registers; the state memory
// has no clearing pass and must be loaded by first-frame beats.
// A stall on m_ready parks one result in the skid register; the whole pipe then holds.

module temporal_bandpass_amplifier_top #(
    parameter int LEVELS       = tbpa_pkg::LEVELS_DEF,
    parameter int STORE_DEPTH  = tbpa_pkg::STORE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = tbpa_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tbpa_pkg::LEVEL_W-1:0]         s_level,
    input  logic [tbpa_pkg::ADDR_W-1:0]          s_address,
    input  logic                                 s_first_frame,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_chan_l,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_chan_a,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_chan_b,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tbpa_pkg::ADDR_W-1:0]          m_out_address,
    output logic signed [SAMPLE_WIDTH-1:0]       m_motion_l,
    output logic signed [SAMPLE_WIDTH-1:0]       m_motion_a,
    output logic signed [SAMPLE_WIDTH-1:0]       m_motion_b,

    input  logic                                 cfg_we,
    input  logic [tbpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tbpa_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int SW        = SAMPLE_WIDTH;
    localparam int AW        = tbpa_pkg::ADDR_W;
    localparam int NCH       = tbpa_pkg::NUM_CHAN;
    localparam int KW        = tbpa_pkg::KW;
    localparam int IDX_W     = $clog2(STORE_DEPTH);
    localparam int MOD_STEPS = tbpa_pkg::mod_steps(STORE_DEPTH);
    localparam int ROW_W     = NCH * SW;
    localparam int XCW       = SW + KW;        // sample times coefficient
    localparam int LW        = SW + KW + 1;    // filter accumulator
    localparam int EW        = SW + 1;         // band value
    localparam int EGW       = EW + KW;        // band value times level gain
    localparam int PCW       = EGW + KW;       // times chroma gain

    typedef logic signed [SW-1:0] sample_t;

    localparam logic signed [LW-1:0]  RND_Q16 = LW'(32768);
    localparam logic signed [EGW-1:0] RND_L   = EGW'(128);
    localparam logic signed [PCW-1:0] RND_AB  = PCW'(8388608);
    localparam sample_t SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [EGW-1:0] SMAX_EG = EGW'(SMAX);
    localparam logic signed [EGW-1:0] SMIN_EG = EGW'(SMIN);
    localparam logic signed [PCW-1:0] SMAX_PC = PCW'(SMAX);
    localparam logic signed [PCW-1:0] SMIN_PC = PCW'(SMIN);

    // Clamp a gained value to the sample range
    function automatic sample_t sat_eg(input logic signed [EGW-1:0] v);
        if (v > SMAX_EG) begin
            return SMAX;
        end else if (v < SMIN_EG) begin
            return SMIN;
        end
        return SW'(v);
    endfunction

    function automatic sample_t sat_pc(input logic signed [PCW-1:0] v);
        if (v > SMAX_PC) begin
            return SMAX;
        end else if (v < SMIN_PC) begin
            return SMIN;
        end
        return SW'(v);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tbpa_pkg::CFG_W-1:0] coef_high_reg;
    logic [tbpa_pkg::CFG_W-1:0] coef_low_reg;
    logic [tbpa_pkg::CFG_W-1:0] chroma_gain_reg;
    logic [tbpa_pkg::CFG_W-1:0] gain_level1_reg;
    logic [tbpa_pkg::CFG_W-1:0] gain_level2_reg;
    logic [tbpa_pkg::CFG_W-1:0] gain_level3_reg;
    logic [KW-1:0]              k_high_reg;     // one minus coef_high
    logic [KW-1:0]              k_low_reg;      // one minus coef_low

    // Write registers; keep the coefficient complements alongside
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_high_reg   <= tbpa_pkg::COEF_HIGH_RST;
            coef_low_reg    <= tbpa_pkg::COEF_LOW_RST;
            chroma_gain_reg <= tbpa_pkg::CHROMA_GAIN_RST;
            gain_level1_reg <= tbpa_pkg::GAIN_LEVEL_RST;
            gain_level2_reg <= tbpa_pkg::GAIN_LEVEL_RST;
            gain_level3_reg <= tbpa_pkg::GAIN_LEVEL_RST;
            k_high_reg      <= tbpa_pkg::ONE_Q16 - {1'b0, tbpa_pkg::COEF_HIGH_RST};
            k_low_reg       <= tbpa_pkg::ONE_Q16 - {1'b0, tbpa_pkg::COEF_LOW_RST};
        end else if (cfg_we) begin
            case (cfg_index)
                tbpa_pkg::CFG_COEF_HIGH: begin
                    coef_high_reg <= cfg_wdata;
                    k_high_reg    <= tbpa_pkg::ONE_Q16 - {1'b0, cfg_wdata};
                end
                tbpa_pkg::CFG_COEF_LOW: begin
                    coef_low_reg <= cfg_wdata;
                    k_low_reg    <= tbpa_pkg::ONE_Q16 - {1'b0, cfg_wdata};
                end
                tbpa_pkg::CFG_CHROMA_GAIN: chroma_gain_reg <= cfg_wdata;
                tbpa_pkg::CFG_GAIN_LEVEL1: gain_level1_reg <= cfg_wdata;
                tbpa_pkg::CFG_GAIN_LEVEL2: gain_level2_reg <= cfg_wdata;
                tbpa_pkg::CFG_GAIN_LEVEL3: gain_level3_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic m_valid_reg;
    logic pipe_en;
    logic m_load;

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;
    assign m_load  = !m_valid_reg || m_ready;

    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;

    // Advance valid bits together with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: input beat; fold address into the store, decode level
    // ------------------------------------------------------------------
    logic [tbpa_pkg::LEVEL_W-1:0] a_level_reg;
    logic [AW-1:0]                a_addr_reg;
    logic                         a_first_reg;
    sample_t                      a_x_reg [NCH];
    logic [AW-1:0]                a_rem;
    logic [IDX_W-1:0]             a_idx_next;
    logic                         a_active_next;

    always_comb begin
        a_rem = a_addr_reg;
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (32'(a_rem) >= (32'(STORE_DEPTH) << k)) begin
                a_rem = a_rem - AW'(32'(STORE_DEPTH) << k);
            end
        end
        a_idx_next = IDX_W'(a_rem);
    end

    assign a_active_next = !a_first_reg
                        && (a_level_reg != tbpa_pkg::LEVEL_FINEST)
                        && (int'(a_level_reg) < LEVELS)
                        && (a_level_reg <= tbpa_pkg::LEVEL_THREE);

    // ------------------------------------------------------------------
    // Stage B: index ready; issue memory read, form input products
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]             b_idx_reg;
    logic [AW-1:0]                b_addr_reg;
    logic [tbpa_pkg::LEVEL_W-1:0] b_level_reg;
    logic                         b_first_reg;
    logic                         b_active_reg;
    sample_t                      b_x_reg [NCH];
    logic signed [XCW-1:0]        b_xc_fast [NCH];
    logic signed [XCW-1:0]        b_xc_slow [NCH];
    logic signed [LW-1:0]         b_xcr_fast_next [NCH];
    logic signed [LW-1:0]         b_xcr_slow_next [NCH];

    // Input term of the filter: x*c plus one half
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            b_xc_fast[ch]       = b_x_reg[ch] * $signed({1'b0, coef_high_reg});
            b_xc_slow[ch]       = b_x_reg[ch] * $signed({1'b0, coef_low_reg});
            b_xcr_fast_next[ch] = LW'(b_xc_fast[ch]) + RND_Q16;
            b_xcr_slow_next[ch] = LW'(b_xc_slow[ch]) + RND_Q16;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: state read back; forward and run the filter recurrence
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]             c_idx_reg;
    logic [AW-1:0]                c_addr_reg;
    logic [tbpa_pkg::LEVEL_W-1:0] c_level_reg;
    logic                         c_first_reg;
    logic                         c_active_reg;
    sample_t                      c_x_reg [NCH];
    logic signed [LW-1:0]         c_xcr_fast_reg [NCH];
    logic signed [LW-1:0]         c_xcr_slow_reg [NCH];
    logic [ROW_W-1:0]             rd_fast_reg;
    logic [ROW_W-1:0]             rd_slow_reg;

    logic [IDX_W-1:0]             d_idx_reg;
    logic [AW-1:0]                d_addr_reg;
    logic [tbpa_pkg::LEVEL_W-1:0] d_level_reg;
    logic                         d_active_reg;
    sample_t                      d_fast_reg [NCH];
    sample_t                      d_slow_reg [NCH];

    logic [IDX_W-1:0]             e_idx_reg;
    sample_t                      e_fast_reg [NCH];
    sample_t                      e_slow_reg [NCH];

    logic                         c_hit_d;
    logic                         c_hit_e;
    sample_t                      c_lp_fast [NCH];
    sample_t                      c_lp_slow [NCH];
    logic signed [LW-1:0]         c_acc_fast [NCH];
    logic signed [LW-1:0]         c_acc_slow [NCH];
    sample_t                      d_fast_next [NCH];
    sample_t                      d_slow_next [NCH];

    // The memory read misses the two writes still in flight: take them from D and E
    assign c_hit_d = d_valid_reg && (d_idx_reg == c_idx_reg);
    assign c_hit_e = e_valid_reg && (e_idx_reg == c_idx_reg);

    // lp_new = (lp*(1-c) + x*c + half) >> 16, or load x on a first frame
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            if (c_hit_d) begin
                c_lp_fast[ch] = d_fast_reg[ch];
                c_lp_slow[ch] = d_slow_reg[ch];
            end else if (c_hit_e) begin
                c_lp_fast[ch] = e_fast_reg[ch];
                c_lp_slow[ch] = e_slow_reg[ch];
            end else begin
                c_lp_fast[ch] = rd_fast_reg[ch*SW +: SW];
                c_lp_slow[ch] = rd_slow_reg[ch*SW +: SW];
            end
            c_acc_fast[ch] = c_lp_fast[ch] * $signed({1'b0, k_high_reg}) + c_xcr_fast_reg[ch];
            c_acc_slow[ch] = c_lp_slow[ch] * $signed({1'b0, k_low_reg}) + c_xcr_slow_reg[ch];
            if (c_first_reg) begin
                d_fast_next[ch] = c_x_reg[ch];
                d_slow_next[ch] = c_x_reg[ch];
            end else begin
                d_fast_next[ch] = SW'(c_acc_fast[ch] >>> 16);
                d_slow_next[ch] = SW'(c_acc_slow[ch] >>> 16);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: new states; write back, band value times level gain
    // ------------------------------------------------------------------
    logic [tbpa_pkg::CFG_W-1:0]   d_gain;
    logic signed [EW-1:0]         d_diff [NCH];
    logic signed [EGW-1:0]        d_eg_next [NCH];
    logic [ROW_W-1:0]             d_row_fast;
    logic [ROW_W-1:0]             d_row_slow;

    always_comb begin
        case (d_level_reg)
            tbpa_pkg::LEVEL_ONE:   d_gain = gain_level1_reg;
            tbpa_pkg::LEVEL_TWO:   d_gain = gain_level2_reg;
            tbpa_pkg::LEVEL_THREE: d_gain = gain_level3_reg;
            default:               d_gain = gain_level1_reg;
        endcase
    end

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            d_diff[ch]                = EW'(d_fast_reg[ch]) - EW'(d_slow_reg[ch]);
            d_eg_next[ch]             = d_diff[ch] * $signed({1'b0, d_gain});
            d_row_fast[ch*SW +: SW]   = d_fast_reg[ch];
            d_row_slow[ch*SW +: SW]   = d_slow_reg[ch];
        end
    end

    // ------------------------------------------------------------------
    // State memories: read at B, write at D
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] mem_fast [STORE_DEPTH];
    logic [ROW_W-1:0] mem_slow [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rd_fast_reg <= mem_fast[b_idx_reg];
            rd_slow_reg <= mem_slow[b_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && d_valid_reg) begin
            mem_fast[d_idx_reg] <= d_row_fast;
            mem_slow[d_idx_reg] <= d_row_slow;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: chroma scaling of a and b
    // ------------------------------------------------------------------
    logic [AW-1:0]                e_addr_reg;
    logic                         e_active_reg;
    logic signed [EGW-1:0]        e_eg_reg [NCH];
    logic signed [PCW-1:0]        e_pc_a_next;
    logic signed [PCW-1:0]        e_pc_b_next;

    assign e_pc_a_next = e_eg_reg[tbpa_pkg::CH_A] * $signed({1'b0, chroma_gain_reg});
    assign e_pc_b_next = e_eg_reg[tbpa_pkg::CH_B] * $signed({1'b0, chroma_gain_reg});

    // ------------------------------------------------------------------
    // Stage F: round, saturate, zero inactive levels
    // ------------------------------------------------------------------
    logic [AW-1:0]                f_addr_reg;
    logic                         f_active_reg;
    logic signed [EGW-1:0]        f_eg_l_reg;
    logic signed [PCW-1:0]        f_pc_a_reg;
    logic signed [PCW-1:0]        f_pc_b_reg;
    logic signed [EGW-1:0]        f_rnd_l;
    logic signed [PCW-1:0]        f_rnd_a;
    logic signed [PCW-1:0]        f_rnd_b;
    sample_t                      f_l_next;
    sample_t                      f_a_next;
    sample_t                      f_b_next;

    always_comb begin
        f_rnd_l = f_eg_l_reg + RND_L;
        f_rnd_a = f_pc_a_reg + RND_AB;
        f_rnd_b = f_pc_b_reg + RND_AB;
        if (f_active_reg) begin
            f_l_next = sat_eg(f_rnd_l >>> 8);
            f_a_next = sat_pc(f_rnd_a >>> 24);
            f_b_next = sat_pc(f_rnd_b >>> 24);
        end else begin
            f_l_next = '0;
            f_a_next = '0;
            f_b_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // A
            a_level_reg <= s_level;
            a_addr_reg  <= s_address;
            a_first_reg <= s_first_frame;
            a_x_reg[tbpa_pkg::CH_L] <= s_chan_l;
            a_x_reg[tbpa_pkg::CH_A] <= s_chan_a;
            a_x_reg[tbpa_pkg::CH_B] <= s_chan_b;
            // B
            b_idx_reg    <= a_idx_next;
            b_addr_reg   <= a_addr_reg;
            b_level_reg  <= a_level_reg;
            b_first_reg  <= a_first_reg;
            b_active_reg <= a_active_next;
            b_x_reg      <= a_x_reg;
            // C
            c_idx_reg      <= b_idx_reg;
            c_addr_reg     <= b_addr_reg;
            c_level_reg    <= b_level_reg;
            c_first_reg    <= b_first_reg;
            c_active_reg   <= b_active_reg;
            c_x_reg        <= b_x_reg;
            c_xcr_fast_reg <= b_xcr_fast_next;
            c_xcr_slow_reg <= b_xcr_slow_next;
            // D
            d_idx_reg    <= c_idx_reg;
            d_addr_reg   <= c_addr_reg;
            d_level_reg  <= c_level_reg;
            d_active_reg <= c_active_reg;
            d_fast_reg   <= d_fast_next;
            d_slow_reg   <= d_slow_next;
            // E
            e_idx_reg    <= d_idx_reg;
            e_addr_reg   <= d_addr_reg;
            e_active_reg <= d_active_reg;
            e_fast_reg   <= d_fast_reg;
            e_slow_reg   <= d_slow_reg;
            e_eg_reg     <= d_eg_next;
            // F
            f_addr_reg   <= e_addr_reg;
            f_active_reg <= e_active_reg;
            f_eg_l_reg   <= e_eg_reg[tbpa_pkg::CH_L];
            f_pc_a_reg   <= e_pc_a_next;
            f_pc_b_reg   <= e_pc_b_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    logic [AW-1:0] m_addr_reg;
    sample_t       m_l_reg;
    sample_t       m_a_reg;
    sample_t       m_b_reg;
    logic [AW-1:0] skid_addr_reg;
    sample_t       skid_l_reg;
    sample_t       skid_a_reg;
    sample_t       skid_b_reg;

    // Drain the skid first; park a finished beat there when the output is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_load) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= pipe_en && f_valid_reg;
            end
        end else if (pipe_en && f_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            if (skid_valid_reg) begin
                m_addr_reg <= skid_addr_reg;
                m_l_reg    <= skid_l_reg;
                m_a_reg    <= skid_a_reg;
                m_b_reg    <= skid_b_reg;
            end else begin
                m_addr_reg <= f_addr_reg;
                m_l_reg    <= f_l_next;
                m_a_reg    <= f_a_next;
                m_b_reg    <= f_b_next;
            end
        end else if (pipe_en) begin
            skid_addr_reg <= f_addr_reg;
            skid_l_reg    <= f_l_next;
            skid_a_reg    <= f_a_next;
            skid_b_reg    <= f_b_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_address = m_addr_reg;
    assign m_motion_l    = m_l_reg;
    assign m_motion_a    = m_a_reg;
    assign m_motion_b    = m_b_reg;

endmodule

FILE: hw/rtl/tbpa_checker.sv
// Port-level checks of the temporal band-pass amplifier, bound to its top level.
`timescale 1ns / 1ps

module tbpa_checker #(
    parameter int SAMPLE_WIDTH = tbpa_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [tbpa_pkg::ADDR_W-1:0]       m_out_address,
    input logic signed [SAMPLE_WIDTH-1:0]    m_motion_l,
    input logic signed [SAMPLE_WIDTH-1:0]    m_motion_a,
    input logic signed [SAMPLE_WIDTH-1:0]    m_motion_b
);

    // No result is shown right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A held result stays valid
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped while stalled");

    // A held result keeps its payload
    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_address) && $stable(m_motion_l)
                                && $stable(m_motion_a) && $stable(m_motion_b))
        else $error("result payload changed while stalled");

    // Input is refused only while a result waits at the output
    a_refuse_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with no result pending");

    // Input closes only after the output was stalled
    a_refuse_after_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready fell without an output stall");

endmodule

bind temporal_bandpass_amplifier_top tbpa_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_tbpa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_address (m_out_address),
    .m_motion_l    (m_motion_l),
    .m_motion_a    (m_motion_a),
    .m_motion_b    (m_motion_b)
);
